// ----- rtl/rrcms_pkg.sv -----
`timescale 1ns / 1ps
package rrcms_pkg;

  localparam int unsigned SLOTS_PER_STAGE_DEF = 32;
  localparam int unsigned STAGE_COUNT_DEF     = 7;
  localparam int unsigned VALUE_WIDTH_DEF     = 32;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAGE_W = 3;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned FIELD_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_SWEEP = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              wr;
    logic              clr;
    logic [STAGE_W-1:0] stage;
    logic [SLOT_W-1:0]  slot;
    logic              en;
  } tbl_ctl_t;

endpackage

// ----- rtl/range_remap_chain_min_search_core.sv -----
`timescale 1ns / 1ps
// Range remap chain with a running minimum.
// One input channel (in_*) carries write, sweep, clear and no-op commands;
// one output channel (out_*) returns one result transaction per command.
// A write stores an entry into a stage table and answers in the next cycle.
// A clear disables every entry, resets the minimum, and answers in the next cycle.
// A sweep feeds one value per cycle from seed_start into a chain of
// STAGE_COUNT cells, each holding one stage table and one pipeline register.
// A sweep answers once its last value has left the last cell.
// Sweeps stop at the top value.
// The block takes one command at a time; the next is accepted once the
// output register is empty or in the cycle in which its result leaves.
// Reset disables all entries and sets the minimum and last result to all ones.
// When the receiver stalls, the result stays in the output register unchanged.
module range_remap_chain_min_search_core #(
  parameter int unsigned SLOTS_PER_STAGE = rrcms_pkg::SLOTS_PER_STAGE_DEF,
  parameter int unsigned STAGE_COUNT     = rrcms_pkg::STAGE_COUNT_DEF,
  parameter int unsigned VALUE_WIDTH     = rrcms_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rrcms_pkg::CMD_W-1:0]   in_cmd,
  input  logic [rrcms_pkg::STAGE_W-1:0] in_stage,
  input  logic [rrcms_pkg::SLOT_W-1:0]  in_slot,
  input  logic [VALUE_WIDTH-1:0]        in_src_start,
  input  logic [VALUE_WIDTH-1:0]        in_dst_start,
  input  logic [VALUE_WIDTH-1:0]        in_span_length,
  input  logic                          in_entry_valid,
  input  logic [VALUE_WIDTH-1:0]        in_seed_start,
  input  logic [rrcms_pkg::FIELD_W-1:0] in_seed_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [VALUE_WIDTH-1:0]        out_min_location,
  output logic [VALUE_WIDTH-1:0]        out_last_location,
  output logic                          out_status
);
  import rrcms_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN} state_t;

  state_t state_r;
  logic [VALUE_WIDTH-1:0] cur_r, top_r;
  logic [VALUE_WIDTH-1:0] min_r, last_r;
  logic out_valid_r, status_r;
  logic accept;
  tbl_ctl_t ctl;

  logic [STAGE_COUNT:0]   cv;
  logic [STAGE_COUNT:0]   cl;
  logic [VALUE_WIDTH-1:0] cd [STAGE_COUNT+1];

  logic [VALUE_WIDTH:0] top_sum;
  logic                 bad;

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign bad      = (32'(in_stage) >= STAGE_COUNT) || (32'(in_slot) >= SLOTS_PER_STAGE);
  assign top_sum  = {1'b0, in_seed_start} + (VALUE_WIDTH+1)'(in_seed_count - 1'b1);

  assign ctl.wr    = accept && (cmd_t'(in_cmd) == CMD_WRITE);
  assign ctl.clr   = accept && (cmd_t'(in_cmd) == CMD_CLEAR);
  assign ctl.stage = in_stage;
  assign ctl.slot  = in_slot;
  assign ctl.en    = in_entry_valid;

  assign cv[0] = (state_r == ST_ISSUE);
  assign cl[0] = (cur_r == top_r);
  assign cd[0] = cur_r;

  for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_cell
    rrcms_cell #(
      .SLOTS(SLOTS_PER_STAGE),
      .VW   (VALUE_WIDTH),
      .IDX  (s)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_src  (in_src_start),
      .wr_dst  (in_dst_start),
      .wr_len  (in_span_length),
      .v_in    (cv[s]),
      .last_in (cl[s]),
      .d_in    (cd[s]),
      .v_out   (cv[s+1]),
      .last_out(cl[s+1]),
      .d_out   (cd[s+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= '1;
      last_r      <= '1;
      out_valid_r <= 1'b0;
      status_r    <= 1'b0;
      cur_r       <= '0;
      top_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cv[STAGE_COUNT] && cd[STAGE_COUNT] < min_r) begin
        min_r <= cd[STAGE_COUNT];
      end
      if (cv[STAGE_COUNT] && cl[STAGE_COUNT]) begin
        last_r <= cd[STAGE_COUNT];
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            status_r <= 1'b0;
            unique case (cmd_t'(in_cmd))
              CMD_WRITE: begin
                status_r    <= bad;
                out_valid_r <= 1'b1;
              end
              CMD_SWEEP: begin
                if (in_seed_count == '0) begin
                  out_valid_r <= 1'b1;
                end else begin
                  cur_r   <= in_seed_start;
                  top_r   <= top_sum[VALUE_WIDTH] ? '1 : top_sum[VALUE_WIDTH-1:0];
                  state_r <= ST_ISSUE;
                end
              end
              CMD_CLEAR: begin
                min_r       <= '1;
                out_valid_r <= 1'b1;
              end
              CMD_NOP: begin
                out_valid_r <= 1'b1;
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        ST_ISSUE: begin
          if (cur_r == top_r) begin
            state_r <= ST_DRAIN;
          end else begin
            cur_r <= cur_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (cv[STAGE_COUNT] && cl[STAGE_COUNT]) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    out_valid         = out_valid_r;
    out_status        = status_r;
    out_min_location  = min_r;
    out_last_location = last_r;
  end
endmodule

// ----- rtl/rrcms_cell.sv -----
`timescale 1ns / 1ps
module rrcms_cell #(
  parameter int unsigned SLOTS = rrcms_pkg::SLOTS_PER_STAGE_DEF,
  parameter int unsigned VW    = rrcms_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned IDX   = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rrcms_pkg::tbl_ctl_t  ctl,
  input  logic [VW-1:0]        wr_src,
  input  logic [VW-1:0]        wr_dst,
  input  logic [VW-1:0]        wr_len,
  input  logic                 v_in,
  input  logic                 last_in,
  input  logic [VW-1:0]        d_in,
  output logic                 v_out,
  output logic                 last_out,
  output logic [VW-1:0]        d_out
);
  import rrcms_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NP = 1 << SW;

  logic [VW-1:0] src_r [SLOTS];
  logic [VW-1:0] dst_r [SLOTS];
  logic [VW-1:0] len_r [SLOTS];
  logic [SLOTS-1:0] en_r;
  logic [SLOTS-1:0] hit;
  logic          tf [NP];
  logic [VW-1:0] ts [NP];
  logic [VW-1:0] td [NP];
  logic [VW-1:0] d_nxt;
  logic v_r, last_r;
  logic [VW-1:0] d_r;
  logic wr_here;

  assign wr_here = ctl.wr && (32'(ctl.stage) == IDX) && (32'(ctl.slot) < SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
    end else if (ctl.clr) begin
      en_r <= '0;
    end else if (wr_here) begin
      en_r[SW'(ctl.slot)] <= ctl.en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      src_r[SW'(ctl.slot)] <= wr_src;
      dst_r[SW'(ctl.slot)] <= wr_dst;
      len_r[SW'(ctl.slot)] <= wr_len;
    end
  end

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      hit[k] = en_r[k] && (d_in >= src_r[k])
               && ({1'b0, d_in} < ({1'b0, src_r[k]} + {1'b0, len_r[k]}));
    end
  end

  // The lowest source start wins through a balanced tree; on a tie the lower slot stays.
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      tf[k] = hit[k];
      ts[k] = src_r[k];
      td[k] = dst_r[k];
    end
    for (int k = SLOTS; k < NP; k++) begin
      tf[k] = 1'b0;
      ts[k] = '0;
      td[k] = '0;
    end
    for (int w = 1; w < NP; w = w * 2) begin
      for (int i = 0; i + w < NP; i = i + 2 * w) begin
        if (tf[i+w] && (!tf[i] || ts[i+w] < ts[i])) begin
          tf[i] = 1'b1;
          ts[i] = ts[i+w];
          td[i] = td[i+w];
        end
      end
    end
    d_nxt = tf[0] ? (td[0] + (d_in - ts[0])) : d_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      last_r <= 1'b0;
    end else begin
      v_r    <= v_in;
      last_r <= v_in && last_in;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign v_out    = v_r;
  assign last_out = last_r;
  assign d_out    = d_r;
endmodule
